@@ rtl/fat12_cluster_chain_walker_macros.svh @@
// Assertion macros for the FAT12 cluster chain walker checker.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH

// Implication checked on every rising edge outside reset
`define FC12_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Plain condition checked on every rising edge outside reset
`define FC12_ASSERT_COND(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

@@ rtl/fc12_pkg.sv @@
// Shared types and constants of the FAT12 cluster chain walker.
// No dependencies; used by every RTL file of the block except fc12_ram and the macro header.
package fc12_pkg;

	// Default FAT store size in bytes
	localparam int unsigned FAT_BYTES_DEF = 8192;

	// Command codes
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_START   = 2'd1;
	localparam logic [1:0] OP_ADVANCE = 2'd2;

	// Configuration register indexes
	localparam logic CFG_DATA_START  = 1'b0;
	localparam logic CFG_SECTORS_CLU = 1'b1;

	// Clusters at or above this mark end the chain
	localparam logic [11:0] END_MARK = 12'hFF8;
	localparam logic [11:0] FIRST_DATA_CLUSTER = 12'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [12:0] fat_byte_index;
		logic [7:0]  fat_byte_value;
		logic [11:0] start_cluster;
	} cmd_t;

	typedef struct packed {
		logic [11:0] cluster_number;
		logic [23:0] sector_lba;
		logic        chain_end;
		logic        bad_cluster;
	} res_t;

	// FAT byte write request toward the store
	typedef struct packed {
		logic        en;
		logic [12:0] index;
		logic [7:0]  value;
	} fat_wr_t;

endpackage

@@ rtl/fc12_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// No package dependencies.
module fc12_ram #(
	parameter int unsigned Depth = 4096,
	parameter int unsigned AddrW = 12,
	parameter int unsigned DataW = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [DataW-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [DataW-1:0] rdata
);

	logic [DataW-1:0] mem [Depth];
	logic [DataW-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/fc12_fat_store.sv @@
// FAT byte store split into even and odd byte banks so both bytes of a pair are read together.
// Depends on fc12_pkg and fc12_ram; extracts the 12-bit next-cluster entry.
module fc12_fat_store #(
	parameter int unsigned FAT_BYTES = fc12_pkg::FAT_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fc12_pkg::fat_wr_t wr,
	input  logic             rd_en,
	input  logic [11:0]      rd_cluster,
	output logic [11:0]      link_cluster
);

	localparam int unsigned AddrW    = $clog2(FAT_BYTES);
	localparam int unsigned RowW     = AddrW - 1;
	localparam int unsigned EvenRows = (FAT_BYTES + 1) / 2;
	localparam int unsigned OddRows  = FAT_BYTES / 2;

	logic            wr_in_range;
	logic            even_we, odd_we;
	logic [RowW-1:0] wr_row;
	logic [12:0]     offset;
	logic [11:0]     even_row12;
	logic [RowW-1:0] even_raddr, odd_raddr;
	logic [7:0]      even_rdata, odd_rdata;
	logic            off_odd_s1, clu_odd_s1;
	logic [15:0]     pair;

	// write decode: bank by byte parity, drop offsets beyond the store
	assign wr_in_range = 32'(wr.index) < FAT_BYTES;
	assign even_we     = wr.en && wr_in_range && !wr.index[0];
	assign odd_we      = wr.en && wr_in_range && wr.index[0];
	assign wr_row      = RowW'(wr.index[12:1]);

	// entry offset is cluster * 3 / 2; the pair may straddle a bank row
	assign offset     = 13'(rd_cluster) + 13'(rd_cluster[11:1]);
	assign even_row12 = offset[12:1] + 12'(offset[0]);
	assign even_raddr = RowW'(even_row12);
	assign odd_raddr  = RowW'(offset[12:1]);

	fc12_ram #(
		.Depth(EvenRows),
		.AddrW(RowW),
		.DataW(8)
	) u_even (
		.clk  (clk),
		.we   (even_we),
		.waddr(wr_row),
		.wdata(wr.value),
		.re   (rd_en),
		.raddr(even_raddr),
		.rdata(even_rdata)
	);

	fc12_ram #(
		.Depth(OddRows),
		.AddrW(RowW),
		.DataW(8)
	) u_odd (
		.clk  (clk),
		.we   (odd_we),
		.waddr(wr_row),
		.wdata(wr.value),
		.re   (rd_en),
		.raddr(odd_raddr),
		.rdata(odd_rdata)
	);

	// parity of offset and cluster, aligned with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_odd_s1 <= 1'b0;
			clu_odd_s1 <= 1'b0;
		end else if (rd_en) begin
			off_odd_s1 <= offset[0];
			clu_odd_s1 <= rd_cluster[0];
		end
	end

	// little-endian pair, then low or high 12 bits
	assign pair = off_odd_s1 ? {even_rdata, odd_rdata} : {odd_rdata, even_rdata};
	assign link_cluster = clu_odd_s1 ? pair[15:4] : pair[11:0];

endmodule

@@ rtl/fat12_cluster_chain_walker.sv @@
// FAT12 cluster chain walker, top level.
// Depends on fc12_pkg and fc12_fat_store (which uses fc12_ram).
//
// Usage:
//   Commands enter on cmd, taken at a rising edge with start high and busy low.
//   A write command stores one FAT byte and returns nothing; busy stays low.
//   A start command makes start_cluster current; an advance command follows
//   the FAT entry of the current cluster. Each returns one transaction on
//   result, marked by done for exactly one cycle.
//   An advance passes through byte pair read, cluster update and result
//   register; a start skips the read, and an advance past the end of the
//   chain goes straight to the result register. Starts and advances are not
//   overlapped; one write per cycle; a new command is taken while done shows.
//   The receiver cannot stall; results must be taken when done is high.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) are registered; the
//   user must make them only while the block is idle; the block does not enforce it.
//   Reset clears the chain (cluster 0, chain finished) and sets data_start_lba
//   to 0 and sectors_per_cluster to 1; FAT bytes must be written before use.
module fat12_cluster_chain_walker #(
	parameter int unsigned FAT_BYTES = fc12_pkg::FAT_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  fc12_pkg::cmd_t cmd,
	output logic           done,
	output fc12_pkg::res_t result,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [15:0]    cfg_wdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [11:0]       cur_q;
	logic              fin_q;
	logic              done_q;
	fc12_pkg::res_t    res_q;
	logic [15:0]       data_start_q;
	logic [7:0]        spc_q;

	logic              accept;
	logic              rd_en;
	fc12_pkg::fat_wr_t fat_wr;
	logic [11:0]       link_cluster;
	logic [11:0]       clu_off;
	logic [19:0]       product;
	logic [23:0]       lba;
	logic              bad;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;

	// FAT write and read requests
	assign fat_wr.en    = accept && (cmd.operation == fc12_pkg::OP_WRITE);
	assign fat_wr.index = cmd.fat_byte_index;
	assign fat_wr.value = cmd.fat_byte_value;
	assign rd_en = accept && (cmd.operation == fc12_pkg::OP_ADVANCE) && !fin_q;

	fc12_fat_store #(
		.FAT_BYTES(FAT_BYTES)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (fat_wr),
		.rd_en       (rd_en),
		.rd_cluster  (cur_q),
		.link_cluster(link_cluster)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= '0;
			spc_q        <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				fc12_pkg::CFG_DATA_START:  data_start_q <= cfg_wdata;
				fc12_pkg::CFG_SECTORS_CLU: spc_q        <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// first sector of the current cluster
	always_comb begin
		clu_off = cur_q - fc12_pkg::FIRST_DATA_CLUSTER;
		product = 20'(clu_off) * 20'(spc_q);
		lba     = 24'(data_start_q) + 24'(product);
		bad     = !fin_q && (cur_q < fc12_pkg::FIRST_DATA_CLUSTER);
	end

	// sequencer with cluster state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			fin_q   <= 1'b1;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.operation)
							fc12_pkg::OP_START: begin
								cur_q   <= cmd.start_cluster;
								fin_q   <= cmd.start_cluster >= fc12_pkg::END_MARK;
								state_q <= S_OUT;
							end
							fc12_pkg::OP_ADVANCE: begin
								state_q <= fin_q ? S_OUT : S_READ;
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					cur_q   <= link_cluster;
					fin_q   <= link_cluster >= fc12_pkg::END_MARK;
					state_q <= S_OUT;
				end
				S_OUT: begin
					done_q               <= 1'b1;
					res_q.cluster_number <= cur_q;
					res_q.chain_end      <= fin_q;
					res_q.bad_cluster    <= bad;
					res_q.sector_lba     <= (fin_q || bad) ? '0 : lba;
					state_q              <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ rtl/fc12_checker.sv @@
// Port-level checker for the FAT12 cluster chain walker, bound to the top level.
// Depends on fc12_pkg and fat12_cluster_chain_walker_macros.svh.
`include "fat12_cluster_chain_walker_macros.svh"

module fc12_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input fc12_pkg::cmd_t cmd,
	input logic           done,
	input fc12_pkg::res_t result
);

	logic acc_write, acc_start, acc_adv;

	assign acc_write = start && !busy && (cmd.operation == fc12_pkg::OP_WRITE);
	assign acc_start = start && !busy && (cmd.operation == fc12_pkg::OP_START);
	assign acc_adv   = start && !busy && (cmd.operation == fc12_pkg::OP_ADVANCE);

	// a result transaction is shown only when the block is free again
	`FC12_ASSERT(a_done_idle, done |-> !busy, "done while busy")

	// a FAT write leaves the block free and produces no result
	`FC12_ASSERT(a_write_silent, acc_write |=> (!busy && !done), "write caused work")

	// start keeps the block busy after accept, then returns its result
	`FC12_ASSERT(a_start_lat, acc_start |=> busy ##1 done, "start result late")

	// advance always makes the block busy after accept, without a result yet
	`FC12_ASSERT(a_adv_busy, acc_adv |=> (busy && !done), "advance not busy")

	// end and bad marks carry no sector and never occur together
	`FC12_ASSERT_COND(a_flags,
		!done || ((!result.chain_end && !result.bad_cluster) ||
		(result.sector_lba == 24'd0 && !(result.chain_end && result.bad_cluster))),
		"flag or sector mismatch")

endmodule

bind fat12_cluster_chain_walker fc12_checker u_fc12_checker (.*);
